FILE: design/cuckoo_filter_engine_assert.svh
// Assertion macros for the cuckoo filter engine.
// Needs clk and arst_n in the scope where a macro is used; no other dependencies.
`ifndef CUCKOO_FILTER_ENGINE_ASSERT_SVH
`define CUCKOO_FILTER_ENGINE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CFE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define CFE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/cfe_pkg.sv
// Shared types, constants and the LFSR step function of the cuckoo filter engine.
// No dependencies.
`timescale 1ns / 1ps

package cfe_pkg;

	localparam int FP_W       = 7;
	localparam int SLOTS      = 4;
	localparam int SLOT_W     = 2;
	localparam int FILL_W     = 3;
	localparam int KICK_W     = 10;
	localparam int SEED_W     = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [KICK_W-1:0] KICKS_RESET = 10'd500;
	localparam logic [SEED_W-1:0] SEED_RESET  = 16'd1;
	localparam logic [SEED_W-1:0] LFSR_TAPS   = 16'hB400;
	localparam logic [FILL_W-1:0] FILL_FULL   = 3'd4;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_KICKS   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_RANDOM_SEED = 1'b1;

	// One bucket row: fill count plus four fingerprint slots.
	typedef struct packed {
		logic [FILL_W-1:0]           fill;
		logic [SLOTS-1:0][FP_W-1:0]  fp;
	} row_t;

	localparam int ROW_W = $bits(row_t);

	// Configuration state seen by the controller.
	typedef struct packed {
		logic [KICK_W-1:0] max_kicks;
		logic [SEED_W-1:0] lfsr;
	} cfg_t;

	function automatic logic [SEED_W-1:0] lfsr_next(input logic [SEED_W-1:0] s);
		logic [SEED_W-1:0] sh;
		sh = s >> 1;
		return s[0] ? (sh ^ LFSR_TAPS) : sh;
	endfunction

endpackage

FILE: design/cuckoo_filter_engine.sv
// Cuckoo filter engine with four-slot buckets: request sequencer and output register.
// Depends on cfe_pkg, cfe_table, cfe_regs and cuckoo_filter_engine_assert.svh.
`timescale 1ns / 1ps
`include "cuckoo_filter_engine_assert.svh"

// Cuckoo filter over NUM_BUCKETS buckets (a power of two), each holding four 7-bit
// fingerprints and a fill count in one row of a single-port-read, single-port-write
// table with registered read data. A request carries a 64-bit key hash; the
// fingerprint is its low 7 bits, the first bucket its low log2(NUM_BUCKETS) bits and
// the alternate bucket that index XOR the fingerprint. Requests are handled one at a
// time, and the result register sits after the sequencer, so the next request is
// taken while a result still waits for out_ready. Steps per request: an insert into the
// first bucket reads that bucket, then examines it and writes it back; a lookup or an
// insert into the alternate bucket reads the first bucket, examines it while reading the
// alternate one, then examines that; an evicting insert reads a drawn start bucket and
// per kick writes back the victim row, re-reads the target bucket and examines it.
// The steps follow from the table's single read port and registered read data. A result
// that finds the output register full waits in the sequencer. After reset the block
// sweeps the table once to zero the fill counts, one bucket per cycle, which holds
// in_ready low until the sweep ends; configuration writes are taken meanwhile and
// must otherwise arrive only while no request is in flight.
module cuckoo_filter_engine import cfe_pkg::*; #(
	parameter int NUM_BUCKETS = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  operation,
	input  logic [63:0]           key_hash,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  success,
	output logic [KICK_W-1:0]     kicks_used,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
	localparam logic [BW-1:0] LAST_BUCKET = BW'(NUM_BUCKETS - 1);

	typedef enum logic [6:0] {
		S_CLR  = 7'b0000001,
		S_IDLE = 7'b0000010,
		S_CHK1 = 7'b0000100,
		S_CHK2 = 7'b0001000,
		S_KMOD = 7'b0010000,
		S_KRD  = 7'b0100000,
		S_KCHK = 7'b1000000
	} state_t;

	state_t            state_q, state_d;
	logic [BW-1:0]     clr_q;
	logic              op_q, op_d;
	logic [FP_W-1:0]   fp_q, fp_d;
	logic [BW-1:0]     b1_q, b1_d;
	logic [BW-1:0]     b2_q, b2_d;
	logic [BW-1:0]     cur_q, cur_d;
	logic [KICK_W-1:0] kcnt_q, kcnt_d;
	logic              hit1_q, hit1_d;

	logic              out_valid_q;
	logic              success_q;
	logic [KICK_W-1:0] kicks_q;

	logic              res_load;
	logic              res_success;
	logic [KICK_W-1:0] res_kicks;
	logic              out_free;

	logic              mem_we, mem_re;
	logic [BW-1:0]     mem_waddr, mem_raddr;
	row_t              mem_wdata;
	logic [ROW_W-1:0]  mem_rdata;

	cfg_t              cfg;
	logic              lfsr_step;
	logic [SEED_W-1:0] lfsr_nx;

	row_t              rd_row;
	row_t              push_row;
	row_t              kick_row;
	logic              room;
	logic              hit;
	logic [SLOT_W-1:0] kick_pos;
	logic [FP_W-1:0]   displaced;
	logic [BW-1:0]     key_b1;

	cfe_table #(
		.DEPTH (NUM_BUCKETS),
		.AW    (BW),
		.DW    (ROW_W)
	) u_table (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	cfe_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.step      (lfsr_step),
		.cfg       (cfg)
	);

	assign lfsr_nx  = lfsr_next(cfg.lfsr);
	assign rd_row   = row_t'(mem_rdata);
	assign out_free = !out_valid_q || out_ready;
	assign key_b1   = key_hash[BW-1:0];

	// Examine the bucket row that the last read returned.
	always_comb begin
		room = rd_row.fill < FILL_FULL;
		hit  = 1'b0;
		for (int j = 0; j < SLOTS; j++) begin
			if ((FILL_W'(j) < rd_row.fill) && (rd_row.fp[j] == fp_q)) begin
				hit = 1'b1;
			end
		end

		// append the fingerprint in hand behind the filled slots
		push_row = rd_row;
		push_row.fp[rd_row.fill[SLOT_W-1:0]] = fp_q;
		push_row.fill = rd_row.fill + 1'b1;

		// swap the fingerprint in hand with a random slot
		kick_pos  = lfsr_nx[SLOT_W-1:0];
		displaced = rd_row.fp[kick_pos];
		kick_row  = rd_row;
		kick_row.fp[kick_pos] = fp_q;
	end

	// Request sequencer.
	always_comb begin
		state_d     = state_q;
		op_d        = op_q;
		fp_d        = fp_q;
		b1_d        = b1_q;
		b2_d        = b2_q;
		cur_d       = cur_q;
		kcnt_d      = kcnt_q;
		hit1_d      = hit1_q;
		in_ready    = 1'b0;
		mem_we      = 1'b0;
		mem_waddr   = cur_q;
		mem_wdata   = push_row;
		mem_re      = 1'b0;
		mem_raddr   = cur_q;
		lfsr_step   = 1'b0;
		res_load    = 1'b0;
		res_success = 1'b0;
		res_kicks   = '0;

		unique case (state_q)
			S_CLR: begin
				// zero the fill count of one bucket per cycle
				mem_we         = 1'b1;
				mem_waddr      = clr_q;
				mem_wdata      = '0;
				if (clr_q == LAST_BUCKET) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					op_d      = operation;
					fp_d      = key_hash[FP_W-1:0];
					b1_d      = key_b1;
					b2_d      = key_b1 ^ BW'(key_hash[FP_W-1:0]);
					mem_re    = 1'b1;
					mem_raddr = key_b1;
					state_d   = S_CHK1;
				end
			end
			S_CHK1: begin
				if (out_free) begin
					if (op_q == OP_LOOKUP) begin
						hit1_d    = hit;
						mem_re    = 1'b1;
						mem_raddr = b2_q;
						state_d   = S_CHK2;
					end else if (room) begin
						mem_we      = 1'b1;
						mem_waddr   = b1_q;
						res_load    = 1'b1;
						res_success = 1'b1;
						state_d     = S_IDLE;
					end else begin
						mem_re    = 1'b1;
						mem_raddr = b2_q;
						state_d   = S_CHK2;
					end
				end
			end
			S_CHK2: begin
				if (out_free) begin
					if (op_q == OP_LOOKUP) begin
						res_load    = 1'b1;
						res_success = hit1_q || hit;
						state_d     = S_IDLE;
					end else if (room) begin
						mem_we      = 1'b1;
						mem_waddr   = b2_q;
						res_load    = 1'b1;
						res_success = 1'b1;
						state_d     = S_IDLE;
					end else begin
						// both full: draw the start bucket of the eviction chain
						lfsr_step = 1'b1;
						cur_d     = lfsr_nx[0] ? b2_q : b1_q;
						kcnt_d    = '0;
						if (cfg.max_kicks == '0) begin
							res_load = 1'b1;
							state_d  = S_IDLE;
						end else begin
							mem_re    = 1'b1;
							mem_raddr = cur_d;
							state_d   = S_KMOD;
						end
					end
				end
			end
			S_KMOD: begin
				lfsr_step = 1'b1;
				mem_we    = 1'b1;
				mem_waddr = cur_q;
				mem_wdata = kick_row;
				fp_d      = displaced;
				cur_d     = cur_q ^ BW'(displaced);
				kcnt_d    = kcnt_q + 1'b1;
				state_d   = S_KRD;
			end
			S_KRD: begin
				// re-read after the write so a bucket that maps to itself sees the swap
				mem_re    = 1'b1;
				mem_raddr = cur_q;
				state_d   = S_KCHK;
			end
			S_KCHK: begin
				if (out_free) begin
					if (room) begin
						mem_we      = 1'b1;
						mem_waddr   = cur_q;
						res_load    = 1'b1;
						res_success = 1'b1;
						res_kicks   = kcnt_q;
						state_d     = S_IDLE;
					end else if (kcnt_q == cfg.max_kicks) begin
						// drop the fingerprint still in hand
						res_load  = 1'b1;
						res_kicks = cfg.max_kicks;
						state_d   = S_IDLE;
					end else begin
						// the row just read is the next victim bucket
						state_d = S_KMOD;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLR) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	// Request context: payload, no reset.
	always_ff @(posedge clk) begin
		op_q   <= op_d;
		fp_q   <= fp_d;
		b1_q   <= b1_d;
		b2_q   <= b2_d;
		cur_q  <= cur_d;
		kcnt_q <= kcnt_d;
		hit1_q <= hit1_d;
	end

	// Output register: load a finished result, drop it once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			success_q <= res_success;
			kicks_q   <= res_kicks;
		end
	end

	assign out_valid  = out_valid_q;
	assign success    = success_q;
	assign kicks_used = kicks_q;

	`CFE_ASSERT_NOW(a_no_result_overrun, res_load, !out_valid_q || out_ready, "result overwrites one not yet taken")
	`CFE_ASSERT_NOW(a_no_rw_same_cycle, mem_we, !mem_re, "table read and written in one cycle")
	`CFE_ASSERT_NOW(a_kick_bound, state_q == S_KCHK, (kcnt_q != '0) && (kcnt_q <= cfg.max_kicks), "eviction count out of bounds")
	`CFE_ASSERT_NEXT(a_accept_reads, in_valid && in_ready, state_q == S_CHK1, "accepted request did not start a bucket read")

endmodule

FILE: design/cfe_table.sv
// Bucket table memory: one write port, one read port, registered read data.
// Depends on nothing; row width and depth come in as parameters.
`timescale 1ns / 1ps

module cfe_table #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10,
	parameter int DW    = 31
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: design/cfe_regs.sv
// Configuration registers and the LFSR of the cuckoo filter engine.
// Depends on cfe_pkg.
`timescale 1ns / 1ps

module cfe_regs import cfe_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  step,
	output cfg_t                  cfg
);

	logic [KICK_W-1:0] max_kicks_q;
	logic [SEED_W-1:0] lfsr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_kicks_q <= KICKS_RESET;
			lfsr_q      <= SEED_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_MAX_KICKS: begin
					max_kicks_q <= cfg_wdata[KICK_W-1:0];
				end
				REG_RANDOM_SEED: begin
					// a zero seed would lock the LFSR
					lfsr_q <= (cfg_wdata == '0) ? SEED_RESET : cfg_wdata;
				end
				default: begin
					lfsr_q <= lfsr_q;
				end
			endcase
		end else if (step) begin
			lfsr_q <= lfsr_next(lfsr_q);
		end
	end

	assign cfg.max_kicks = max_kicks_q;
	assign cfg.lfsr      = lfsr_q;

endmodule

FILE: sim/cuckoo_filter_checker.sv
// Result checker for the cuckoo filter engine: mirrors the bucket table, the LFSR and the
// configuration, predicts one result per request and compares results in order.
// Depends on cfe_pkg only.
`timescale 1ns / 1ps

module cuckoo_filter_checker import cfe_pkg::*; #(
	parameter int NUM_BUCKETS = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  logic                  operation,
	input  logic [63:0]           key_hash,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  logic                  success,
	input  logic [KICK_W-1:0]     kicks_used,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output int                    mismatches,
	output int                    verdicts_due,
	output int                    requests_seen
);

	localparam int BW = $clog2(NUM_BUCKETS);

	typedef struct packed {
		logic              success;
		logic [KICK_W-1:0] kicks;
	} verdict_t;

	logic [FP_W-1:0]   slot_fp [0:NUM_BUCKETS*SLOTS-1];
	logic [FILL_W-1:0] fill_of [0:NUM_BUCKETS-1];
	logic [SEED_W-1:0] lfsr_q;
	logic [KICK_W-1:0] kick_limit;
	verdict_t          due_verdicts [$];
	verdict_t          want, seen;
	int                n_bad, n_req, i;

	function automatic logic [SEED_W-1:0] lfsr_advance(input logic [SEED_W-1:0] s);
		return {1'b0, s[SEED_W-1:1]} ^ ({SEED_W{s[0]}} & LFSR_TAPS);
	endfunction

	// Only filled slots are scanned.
	function automatic logic bucket_holds(input logic [BW-1:0] b, input logic [FP_W-1:0] fp);
		logic hit;
		int   j;
		hit = 1'b0;
		for (j = 0; j < SLOTS; j++)
			if (j < fill_of[b] && slot_fp[b * SLOTS + j] == fp)
				hit = 1'b1;
		return hit;
	endfunction

	task automatic store_fp(input logic [BW-1:0] b, input logic [FP_W-1:0] fp);
		slot_fp[b * SLOTS + fill_of[b]] = fp;
		fill_of[b] = fill_of[b] + 1'b1;
	endtask

	task automatic predict(input logic op, input logic [63:0] h, output verdict_t v);
		logic [FP_W-1:0] fp, moved;
		logic [BW-1:0]   b1, b2, cur;
		logic            placed;
		int              k, at;
		fp = h[FP_W-1:0];
		b1 = h[BW-1:0];
		b2 = b1 ^ {{(BW-FP_W){1'b0}}, fp};
		v = '0;
		placed = 1'b0;
		if (op == OP_LOOKUP) begin
			v.success = bucket_holds(b1, fp) || bucket_holds(b2, fp);
		end else if (fill_of[b1] < FILL_FULL) begin
			store_fp(b1, fp);
			v.success = 1'b1;
		end else if (fill_of[b2] < FILL_FULL) begin
			store_fp(b2, fp);
			v.success = 1'b1;
		end else begin
			// both buckets full: one draw picks the start bucket, one per kick picks the slot
			lfsr_q = lfsr_advance(lfsr_q);
			cur = lfsr_q[0] ? b2 : b1;
			for (k = 0; k < kick_limit && !placed; k++) begin
				lfsr_q = lfsr_advance(lfsr_q);
				at = cur * SLOTS + lfsr_q[SLOT_W-1:0];
				moved = slot_fp[at];
				slot_fp[at] = fp;
				fp = moved;
				cur = cur ^ {{(BW-FP_W){1'b0}}, fp};
				if (fill_of[cur] < FILL_FULL) begin
					store_fp(cur, fp);
					placed = 1'b1;
					v.success = 1'b1;
					v.kicks = KICK_W'(k + 1);
				end
			end
			// a chain that runs out drops the fingerprint in hand
			if (!placed)
				v.kicks = kick_limit;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (i = 0; i < NUM_BUCKETS; i++)
				fill_of[i] = '0;
			for (i = 0; i < NUM_BUCKETS * SLOTS; i++)
				slot_fp[i] = '0;
			lfsr_q = SEED_RESET;
			kick_limit = KICKS_RESET;
			due_verdicts.delete();
			n_bad = 0;
			n_req = 0;
		end else begin
			if (cfg_wr_en) begin
				if (cfg_index == REG_MAX_KICKS)
					kick_limit = cfg_wdata[KICK_W-1:0];
				else if (cfg_index == REG_RANDOM_SEED)
					lfsr_q = (cfg_wdata[SEED_W-1:0] == '0) ? 16'd1 : cfg_wdata[SEED_W-1:0];
			end
			// results first: a request taken at this edge cannot already have its result out
			if (out_valid && out_ready) begin
				seen.success = success;
				seen.kicks = kicks_used;
				if (due_verdicts.size() == 0) begin
					$display("%0t: unexpected result, success %0b kicks_used %0d",
						$time, seen.success, seen.kicks);
					n_bad++;
				end else begin
					want = due_verdicts.pop_front();
					if (seen.success !== want.success) begin
						$display("%0t: success expected %0b, actual %0b",
							$time, want.success, seen.success);
						n_bad++;
					end
					if (seen.kicks !== want.kicks) begin
						$display("%0t: kicks_used expected %0d, actual %0d",
							$time, want.kicks, seen.kicks);
						n_bad++;
					end
				end
			end
			if (in_valid && in_ready) begin
				predict(operation, key_hash, want);
				due_verdicts.push_back(want);
				n_req++;
			end
		end
		mismatches <= n_bad;
		verdicts_due <= due_verdicts.size();
		requests_seen <= n_req;
	end

endmodule

FILE: sim/tb.sv
// Testbench top for the cuckoo filter engine: clock, reset, request traffic in bursts,
// result back-pressure, configuration phases, watchdog and verdict.
// Depends on cfe_pkg, cuckoo_filter_checker and the engine RTL.
`timescale 1ns / 1ps

module tb import cfe_pkg::*; ();

	localparam int NUM_BUCKETS = 1024;
	// Longest quiet stretch of a correct run: a 1023-kick chain, the long receiver
	// hold-off or the post-reset sweep; take it several times.
	localparam int STALL_LIMIT = 20000;
	localparam int HOLD_OFF    = 1500;
	localparam int HOLD_AFTER  = 400;
	localparam int SETTLE      = 16;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic                  operation;
	logic [63:0]           key_hash;
	logic                  out_valid;
	logic                  out_ready;
	logic                  success;
	logic [KICK_W-1:0]     kicks_used;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	int                    mismatches;
	int                    verdicts_due;
	int                    requests_seen;
	int                    burst_left;
	logic [63:0]           inserted_keys [$];

	cuckoo_filter_engine #(
		.NUM_BUCKETS(NUM_BUCKETS)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (operation),
		.key_hash  (key_hash),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.success   (success),
		.kicks_used(kicks_used),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	cuckoo_filter_checker #(
		.NUM_BUCKETS(NUM_BUCKETS)
	) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.key_hash     (key_hash),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.success      (success),
		.kicks_used   (kicks_used),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.mismatches   (mismatches),
		.verdicts_due (verdicts_due),
		.requests_seen(requests_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Random key. A hot key lands in one of eight regions: primary bucket
	// {region, 5'b0, fp} with fp in 0..3, alternate bucket {region, 7'b0}. Those few
	// buckets fill quickly, which drives eviction chains and failed inserts.
	function automatic logic [63:0] make_key(input bit hot);
		logic [63:0] k;
		logic [2:0]  region;
		logic [1:0]  fp_low;
		k = {$urandom, $urandom};
		if (hot) begin
			region = 3'($urandom_range(0, 7));
			fp_low = 2'($urandom_range(0, 3));
			k[9:0] = {region, 5'd0, fp_low};
		end
		return k;
	endfunction

	// Offer one request and hold it until taken. Between bursts drop valid for a
	// random gap; now and then a long burst runs with no gap at all.
	task automatic offer(input logic op, input logic [63:0] key);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
				: $urandom_range(1, 20);
		end
		in_valid <= 1'b1;
		operation <= op;
		key_hash <= key;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		burst_left--;
		if (op == OP_INSERT)
			inserted_keys.push_back(key);
	endtask

	// Drain the block, then write both registers. Junk in the unused data bits
	// of the max_kicks write must be ignored.
	task automatic reconfigure(input logic [KICK_W-1:0] mk, input logic [SEED_W-1:0] seed);
		logic [CFG_DATA_W-KICK_W-1:0] junk;
		junk = (CFG_DATA_W-KICK_W)'($urandom);
		in_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (verdicts_due != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_MAX_KICKS;
		cfg_wdata <= {junk, mk};
		@(posedge clk);
		cfg_index <= REG_RANDOM_SEED;
		cfg_wdata <= seed;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Result side: stretches of always-ready, random, mostly-stalled and toggling patterns.
	// Once enough requests went in, hold off for a long stretch so the engine fills
	// up and drops in_ready while the sender keeps offering.
	initial begin : result_sink
		int mode;
		int stretch;
		bit held;
		out_ready = 1'b0;
		held = 1'b0;
		forever begin
			mode = $urandom_range(0, 3);
			stretch = $urandom_range(10, 150);
			repeat (stretch) begin
				if (!held && requests_seen >= HOLD_AFTER) begin
					held = 1'b1;
					out_ready <= 1'b0;
					repeat (HOLD_OFF) @(posedge clk);
				end
				unique case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					2: out_ready <= ($urandom_range(0, 4) == 0);
					default: out_ready <= ~out_ready;
				endcase
				@(posedge clk);
			end
		end
	end

	// Watchdog: end the run when nothing moves on any port for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en)
				quiet = 0;
			else
				quiet++;
		end
		$display("[cuckoo_filter_engine] ERROR");
		$finish;
	end

	initial begin : stimulus
		int                p;
		int                n;
		int                count;
		int                hot_pct;
		int                pick;
		logic [KICK_W-1:0] mk_sel;
		logic [SEED_W-1:0] seed_sel;
		logic [63:0]       key;
		logic              op;

		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = OP_INSERT;
		key_hash = '0;
		cfg_wr_en = 1'b0;
		cfg_index = REG_MAX_KICKS;
		cfg_wdata = '0;
		burst_left = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed, reset configuration (500 kicks, seed 1). The first request waits
		// out the table sweep behind in_ready.
		offer(OP_LOOKUP, 64'd0);                    // empty table
		offer(OP_INSERT, 64'd0);                    // fingerprint 0, both buckets the same
		offer(OP_LOOKUP, 64'd0);
		offer(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF);  // top bucket, largest fingerprint
		offer(OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF);
		offer(OP_LOOKUP, 64'h8000_0000_0000_007F);  // miss
		// fill bucket 133 and then its alternate 128 with fingerprint 5
		for (n = 0; n < 8; n++) begin
			key = 64'h85;
			key[47:40] = 8'(n);
			offer(OP_INSERT, key);
		end
		offer(OP_INSERT, 64'hFEDC_BA98_7654_3085);  // both full: full-length failed chain
		offer(OP_LOOKUP, 64'h0000_0000_0000_0085);
		offer(OP_LOOKUP, 64'h5555_5555_5555_5555);
		offer(OP_INSERT, 64'hAAAA_AAAA_AAAA_AAAA);

		// Zero kicks and a zero seed: evicting inserts now fail at once.
		reconfigure('0, '0);
		offer(OP_INSERT, 64'h0000_0000_0000_0080);
		offer(OP_INSERT, 64'h7000_0000_0000_0085);
		offer(OP_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA);
		offer(OP_LOOKUP, 64'h0000_0000_0000_0080);

		// Random phases; the first keeps the zero-kick setting just written.
		for (p = 0; p < 6; p++) begin
			unique case (p)
				0: begin
					mk_sel = '0;     seed_sel = '0;                     count = 150; hot_pct = 50;
				end
				1: begin
					mk_sel = 10'd1023; seed_sel = 16'hFFFF;             count = 50;  hot_pct = 40;
				end
				2: begin
					mk_sel = 10'd1;  seed_sel = SEED_W'($urandom_range(1, 65535));
					count = 150; hot_pct = 40;
				end
				3: begin
					mk_sel = KICK_W'($urandom_range(2, 60));
					seed_sel = SEED_W'($urandom_range(1, 65535));
					count = 250; hot_pct = 40;
				end
				4: begin
					mk_sel = KICK_W'($urandom_range(2, 60)); seed_sel = 16'd1;
					count = 250; hot_pct = 30;
				end
				default: begin
					mk_sel = KICK_W'($urandom_range(0, 20));
					seed_sel = SEED_W'($urandom_range(1, 65535));
					count = 200; hot_pct = 50;
				end
			endcase
			if (p != 0)
				reconfigure(mk_sel, seed_sel);
			for (n = 0; n < count; n++) begin
				op = ($urandom_range(0, 99) < 55) ? OP_INSERT : OP_LOOKUP;
				key = make_key($urandom_range(0, 99) < hot_pct);
				if (op == OP_LOOKUP && inserted_keys.size() > 0) begin
					// look up a stored key, the same buckets under other upper bits, or a fresh key
					pick = $urandom_range(0, 9);
					if (pick < 7)
						key = inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
					if (pick >= 5 && pick < 7)
						key[63:10] = 54'({$urandom, $urandom});
				end
				offer(op, key);
			end
		end

		// Drain, let the engine settle, then give the verdict.
		in_valid <= 1'b0;
		@(posedge clk);
		while (verdicts_due != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0)
			$display("[cuckoo_filter_engine] OK");
		else
			$display("[cuckoo_filter_engine] ERROR");
		$finish;
	end

endmodule
